@@ hdl/gbnsw_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gbnsw_pkg: shared types and constants for the Go-Back-N sender window
// Codes for actions, emitted packet kinds, status, close phases and the
// controller/datapath command and status groups.
// ---------------------------------------------------------------------------
package gbnsw_pkg;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned OUT_W  = 7;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned TOUT_W = 16;

  localparam logic [OUT_W-1:0] WINDOW_MAX = 7'd64;
  localparam logic [7:0]       ACK_TYPE   = 8'hA1;
  localparam logic [1:0]       END_TRIES_MAX = 2'd3;

  // register indexes
  localparam logic REG_WINDOW_SIZE  = 1'b0;
  localparam logic REG_TIMEOUT      = 1'b1;

  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_RX    = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_CLOSE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_DATA = 2'd1,
    EMIT_END  = 2'd2
  } emit_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_ACK_OK    = 3'd2,
    ST_ACK_NO    = 3'd3,
    ST_MSG_DONE  = 3'd4,
    ST_CLOSED    = 3'd5,
    ST_GAVE_UP   = 3'd6,
    ST_TIMEOUT   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    PH_OPEN    = 2'd0,
    PH_CLOSING = 2'd1,
    PH_CLOSED  = 2'd2,
    PH_GAVE_UP = 2'd3
  } phase_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic step;      // process the input item, load its first result
    logic run_emit;  // load the next result of a resend run
  } gbnsw_cmd_t;

  typedef struct packed {
    logic run_start; // current item starts a run of more than one result
    logic run_last;  // next run result is the final one
  } gbnsw_sts_t;

endpackage : gbnsw_pkg
`default_nettype wire

@@ hdl/gbnsw_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gbnsw_ctrl: sequencing controller
// Owns the handshakes and the output valid; steps the datapath once per item
// and walks resend runs one result per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
module gbnsw_ctrl
  import gbnsw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire gbnsw_sts_t sts_i,
  output gbnsw_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && slot_free && sts_i.run_start) state_d = S_RUN;
      end
      S_RUN: begin
        if (slot_free && sts_i.run_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = slot_free;
        cmd_o.step = in_valid_i && slot_free;
      end
      S_RUN: begin
        cmd_o.run_emit = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.step || cmd_o.run_emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : gbnsw_ctrl
`default_nettype wire

@@ hdl/gbnsw_dp.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gbnsw_dp: window datapath
// Holds sequence numbers, timer, close phase, configuration, the result
// register and the resend run counter.
// ---------------------------------------------------------------------------
module gbnsw_dp
  import gbnsw_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic [1:0]        action_i,
  input  wire logic [7:0]        pkt_type_i,
  input  wire logic [SEQ_W-1:0]  ack_seq_i,
  input  wire logic              last_of_message_i,
  input  wire gbnsw_cmd_t        cmd_i,
  output gbnsw_sts_t             sts_o,
  output logic [1:0]             emit_kind_o,
  output logic [SEQ_W-1:0]       tx_seq_o,
  output logic                   is_resend_o,
  output logic [2:0]             status_o,
  output logic [OUT_W-1:0]       outstanding_o,
  output logic                   last_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > TOUT_W) ? TIMER_BITS : TOUT_W;

  // configuration
  logic [OUT_W-1:0]  win_size_q;
  logic [TOUT_W-1:0] timeout_q;

  // protocol state
  logic [SEQ_W-1:0]      base_q, base_d;
  logic [SEQ_W-1:0]      next_q, next_d;
  logic [TIMER_BITS-1:0] tcnt_q, tcnt_d;
  logic                  trun_q, trun_d;
  phase_e                phase_q, phase_d;
  logic [1:0]            tries_q, tries_d;
  logic [SEQ_W-1:0]      msg_end_q, msg_end_d;
  logic                  msg_pend_q, msg_pend_d;

  // resend run
  logic [SEQ_W-1:0] run_seq_q, run_seq_d;
  logic [OUT_W-1:0] run_left_q, run_left_d;

  // result of the current item
  emit_e            r_kind;
  logic [SEQ_W-1:0] r_seq;
  logic             r_resend;
  status_e          r_status;
  logic             r_last;
  logic             r_run;

  logic [OUT_W-1:0]      outst, eff_win, outst_after;
  logic [TIMER_BITS-1:0] tcnt_inc;
  logic [TOUT_W-1:0]     limit;
  logic                  fire;

  assign outst = OUT_W'(next_q - base_q);

  always_comb begin
    eff_win = win_size_q;
    if (win_size_q == '0) eff_win = OUT_W'(1);
    else if (win_size_q > WINDOW_MAX) eff_win = WINDOW_MAX;
  end

  assign tcnt_inc = (tcnt_q == '1) ? tcnt_q : tcnt_q + TIMER_BITS'(1);
  assign limit    = (timeout_q == '0) ? TOUT_W'(1) : timeout_q;
  assign fire     = CMP_W'(tcnt_inc) >= CMP_W'(limit);

  always_comb begin
    base_d     = base_q;
    next_d     = next_q;
    tcnt_d     = tcnt_q;
    trun_d     = trun_q;
    phase_d    = phase_q;
    tries_d    = tries_q;
    msg_end_d  = msg_end_q;
    msg_pend_d = msg_pend_q;
    r_kind     = EMIT_NONE;
    r_seq      = '0;
    r_resend   = 1'b0;
    r_status   = ST_OK;
    r_last     = 1'b1;
    r_run      = 1'b0;
    case (action_e'(action_i))
      ACT_SEND: begin
        if (phase_q != PH_OPEN || outst >= eff_win || next_q == '1) begin
          r_status = ST_REFUSED;
        end else begin
          next_d = next_q + SEQ_W'(1);
          if (!trun_q) begin
            trun_d = 1'b1;
            tcnt_d = '0;
          end
          if (last_of_message_i) begin
            msg_end_d  = next_q;
            msg_pend_d = 1'b1;
          end
          r_kind = EMIT_DATA;
          r_seq  = next_q;
        end
      end
      ACT_RX: begin
        r_status = ST_ACK_NO;
        if (pkt_type_i == ACK_TYPE) begin
          if (phase_q == PH_OPEN) begin
            if (ack_seq_i >= base_q && ack_seq_i < next_q) begin
              base_d   = ack_seq_i + SEQ_W'(1);
              tcnt_d   = '0;
              trun_d   = (base_d != next_q);
              r_status = ST_ACK_OK;
              if (msg_pend_q && ack_seq_i >= msg_end_q) begin
                msg_pend_d = 1'b0;
                r_status   = ST_MSG_DONE;
              end
            end
          end else if (phase_q == PH_CLOSING && ack_seq_i == next_q) begin
            phase_d  = PH_CLOSED;
            trun_d   = 1'b0;
            tcnt_d   = '0;
            r_status = ST_CLOSED;
          end
        end
      end
      ACT_TICK: begin
        if (trun_q) begin
          tcnt_d = tcnt_inc;
          if (fire) begin
            tcnt_d   = '0;
            r_status = ST_TIMEOUT;
            if (phase_q == PH_CLOSING) begin
              if (tries_q >= END_TRIES_MAX) begin
                phase_d  = PH_GAVE_UP;
                trun_d   = 1'b0;
                r_status = ST_GAVE_UP;
              end else begin
                tries_d  = tries_q + 2'd1;
                r_kind   = EMIT_END;
                r_seq    = next_q;
                r_resend = 1'b1;
              end
            end else if (phase_q == PH_OPEN && outst != '0) begin
              // first packet of the go-back run
              r_kind   = EMIT_DATA;
              r_seq    = base_q;
              r_resend = 1'b1;
              r_last   = (outst == OUT_W'(1));
              r_run    = !r_last;
            end else begin
              trun_d = 1'b0;
            end
          end
        end
      end
      ACT_CLOSE: begin
        if (phase_q != PH_OPEN || outst != '0) begin
          r_status = ST_REFUSED;
        end else begin
          phase_d = PH_CLOSING;
          tries_d = 2'd1;
          trun_d  = 1'b1;
          tcnt_d  = '0;
          r_kind  = EMIT_END;
          r_seq   = next_q;
        end
      end
      default: r_status = ST_OK;
    endcase
  end

  assign outst_after = OUT_W'(next_d[OUT_W-1:0] - base_d[OUT_W-1:0]);

  always_comb begin
    run_seq_d  = run_seq_q;
    run_left_d = run_left_q;
    if (cmd_i.step) begin
      run_seq_d  = base_q + SEQ_W'(1);
      run_left_d = outst - OUT_W'(1);
    end else if (cmd_i.run_emit) begin
      run_seq_d  = run_seq_q + SEQ_W'(1);
      run_left_d = run_left_q - OUT_W'(1);
    end
  end

  assign sts_o.run_start = r_run;
  assign sts_o.run_last  = (run_left_q == OUT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= OUT_W'(8);
      timeout_q  <= TOUT_W'(1000);
      base_q     <= SEQ_W'(1);
      next_q     <= SEQ_W'(1);
      tcnt_q     <= '0;
      trun_q     <= 1'b0;
      phase_q    <= PH_OPEN;
      tries_q    <= '0;
      msg_end_q  <= '0;
      msg_pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_SIZE: win_size_q <= cfg_data_i[OUT_W-1:0];
          REG_TIMEOUT:     timeout_q  <= cfg_data_i[TOUT_W-1:0];
          default:         win_size_q <= win_size_q;
        endcase
      end
      if (cmd_i.step) begin
        base_q     <= base_d;
        next_q     <= next_d;
        tcnt_q     <= tcnt_d;
        trun_q     <= trun_d;
        phase_q    <= phase_d;
        tries_q    <= tries_d;
        msg_end_q  <= msg_end_d;
        msg_pend_q <= msg_pend_d;
      end
    end
  end

  // run counter and result register: payload only
  always_ff @(posedge clk_i) begin
    run_seq_q  <= run_seq_d;
    run_left_q <= run_left_d;
    if (cmd_i.step) begin
      emit_kind_o   <= r_kind;
      tx_seq_o      <= r_seq;
      is_resend_o   <= r_resend;
      status_o      <= r_status;
      outstanding_o <= outst_after;
      last_o        <= r_last;
    end else if (cmd_i.run_emit) begin
      emit_kind_o   <= EMIT_DATA;
      tx_seq_o      <= run_seq_q;
      is_resend_o   <= 1'b1;
      status_o      <= ST_TIMEOUT;
      outstanding_o <= outst;
      last_o        <= (run_left_q == OUT_W'(1));
    end
  end

endmodule : gbnsw_dp
`default_nettype wire

@@ hdl/gbn_sender_window_control.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gbn_sender_window_control: Go-Back-N ARQ sender window control
// Hands out sequence numbers inside the send window, slides the window on
// cumulative acks, runs the retransmit timer and the close handshake.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------
//  in       | in        | in_valid_i / in_ready_o | action, pkt_type, ack_seq,
//           |           |                         | last_of_message
//  out      | out       | out_valid_o/out_ready_i | emit_kind, tx_seq, is_resend,
//           |           |                         | status, outstanding, last
//  cfg      | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Flow: a send, ack, close or run-free tick loads its single result into the
//   output register; the next item is taken in the same cycle the result
//   leaves. A timeout with N packets outstanding emits N results, one per
//   cycle through the output register while it is not stalled, and holds off
//   input until the last one is loaded (the run counter sets this figure).
// Reset: asynchronous, active low; window base and next sequence return to
//   one, timer stopped, phase open, window 8, timeout 1000 ticks.
// Stalls: a stalled output freezes the result register and drops in_ready_o.
// ---------------------------------------------------------------------------
module gbn_sender_window_control
  import gbnsw_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration writes
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  // input items
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       action_i,
  input  wire logic [7:0]       pkt_type_i,
  input  wire logic [SEQ_W-1:0] ack_seq_i,
  input  wire logic             last_of_message_i,
  // result items
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            emit_kind_o,
  output logic [SEQ_W-1:0]      tx_seq_o,
  output logic                  is_resend_o,
  output logic [2:0]            status_o,
  output logic [OUT_W-1:0]      outstanding_o,
  output logic                  last_o
);

  gbnsw_cmd_t cmd;
  gbnsw_sts_t sts;

  // Controller: handshakes, output valid, run sequencing
  gbnsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: window state, timer, close phase, result register
  gbnsw_dp #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .action_i          (action_i),
    .pkt_type_i        (pkt_type_i),
    .ack_seq_i         (ack_seq_i),
    .last_of_message_i (last_of_message_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .emit_kind_o       (emit_kind_o),
    .tx_seq_o          (tx_seq_o),
    .is_resend_o       (is_resend_o),
    .status_o          (status_o),
    .outstanding_o     (outstanding_o),
    .last_o            (last_o)
  );

  // The window never holds more than the largest window.
  a_outst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outstanding_o <= WINDOW_MAX)
    else $error("outstanding count beyond window maximum");

  // Only a go-back run produces a non-final result, and it resends data.
  a_run_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> emit_kind_o == EMIT_DATA && is_resend_o
                               && status_o == ST_TIMEOUT)
    else $error("non-final result is not a data resend");

  // Input stays held off while a run is still being emitted.
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input accepted during a resend run");

  // Consecutive run results carry consecutive sequence numbers.
  a_run_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o && out_ready_i |=>
      out_valid_o && tx_seq_o == $past(tx_seq_o) + SEQ_W'(1))
    else $error("resend run skipped a sequence number");

endmodule : gbn_sender_window_control
`default_nettype wire

@@ verif/gbn_sender_window_control_tb.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gbn_sender_window_control_tb: self-checking bench for the Go-Back-N sender
// A queue of items feeds a valid/ready driver. Every accepted item runs
// through a window predictor that queues the results it must cause. A monitor
// matches each result, field by field, against the oldest queued one. The
// run covers directed corner cases, random phases under several window and
// timeout settings, a long output stall, and a final close handshake.
// ---------------------------------------------------------------------------
module gbn_sender_window_control_tb
  import gbnsw_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 50;

  // one input item as the block sees it
  typedef struct packed {
    action_e          act;
    logic [7:0]       ptype;
    logic [SEQ_W-1:0] ack;
    logic             lom;
  } tx_item_t;

  // one result item
  typedef struct packed {
    emit_e            kind;
    logic [SEQ_W-1:0] seq;
    logic             resend;
    status_e          status;
    logic [OUT_W-1:0] outst;
    logic             is_last;
  } tx_result_t;

  typedef tx_result_t result_q_t[$];

  // sender window state, kept once for checking and once for planning stimulus
  typedef struct packed {
    logic [SEQ_W-1:0]  base;
    logic [SEQ_W-1:0]  nxt;
    logic [TOUT_W-1:0] tcount;
    logic              trun;
    phase_e            phase;
    logic [1:0]        tries;
    logic [SEQ_W-1:0]  msg_end;
    logic              msg_pend;
  } win_state_t;

  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_idx = REG_WINDOW_SIZE;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic [1:0]        in_action = '0;
  logic [7:0]        in_pkt_type = '0;
  logic [SEQ_W-1:0]  in_ack_seq = '0;
  logic              in_lom = 1'b0;
  logic              out_ready = 1'b0;

  wire logic             in_ready_o;
  wire logic             out_valid_o;
  wire logic [1:0]       emit_kind_o;
  wire logic [SEQ_W-1:0] tx_seq_o;
  wire logic             is_resend_o;
  wire logic [2:0]       status_o;
  wire logic [OUT_W-1:0] outstanding_o;
  wire logic             last_o;

  // register copies used by the predictor; written only while the block idles
  logic [6:0]        cfg_win  = 7'd8;
  logic [TOUT_W-1:0] cfg_tout = 16'd1000;

  win_state_t  model_st;
  win_state_t  plan_st;
  tx_item_t    shown;
  tx_item_t    item_q[$];
  tx_result_t  awaited_q[$];

  logic        calm = 1'b0;
  int unsigned hold_ask = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned n_fail = 0;
  int unsigned n_cycles = 0;

  gbn_sender_window_control dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .action_i          (in_action),
    .pkt_type_i        (in_pkt_type),
    .ack_seq_i         (in_ack_seq),
    .last_of_message_i (in_lom),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .emit_kind_o       (emit_kind_o),
    .tx_seq_o          (tx_seq_o),
    .is_resend_o       (is_resend_o),
    .status_o          (status_o),
    .outstanding_o     (outstanding_o),
    .last_o            (last_o)
  );

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // Window predictor
  // ------------------------------------------------------------------------
  function automatic win_state_t fresh_state();
    win_state_t st;
    st.base     = 32'd1;
    st.nxt      = 32'd1;
    st.tcount   = '0;
    st.trun     = 1'b0;
    st.phase    = PH_OPEN;
    st.tries    = '0;
    st.msg_end  = '0;
    st.msg_pend = 1'b0;
    return st;
  endfunction

  function automatic logic [SEQ_W-1:0] in_flight(win_state_t st);
    return st.nxt - st.base;
  endfunction

  // build one result; outstanding always reflects the state after the step
  function automatic tx_result_t mk(emit_e k, logic [SEQ_W-1:0] s, logic rs,
                                    status_e stv, win_state_t st, logic l);
    tx_result_t r;
    r.kind    = k;
    r.seq     = s;
    r.resend  = rs;
    r.status  = stv;
    r.outst   = OUT_W'(in_flight(st));
    r.is_last = l;
    return r;
  endfunction

  // advance the sender state by one item and return the results it causes
  function automatic result_q_t window_step(inout win_state_t st, input tx_item_t it);
    result_q_t        rq;
    logic [SEQ_W-1:0] wmax;
    logic [SEQ_W-1:0] n;
    logic [SEQ_W-1:0] seq;
    logic [16:0]      limit;
    status_e          stv;
    int unsigned      k;
    rq = {};
    // clamp the window register: zero acts as one, oversize as the maximum
    if (cfg_win == 7'd0) wmax = 32'd1;
    else if (cfg_win > WINDOW_MAX) wmax = 32'(WINDOW_MAX);
    else wmax = 32'(cfg_win);
    limit = (cfg_tout == '0) ? 17'd1 : {1'b0, cfg_tout};
    case (it.act)
      ACT_SEND: begin
        if (st.phase != PH_OPEN || in_flight(st) >= wmax || st.nxt == '1) begin
          rq.push_back(mk(EMIT_NONE, '0, 1'b0, ST_REFUSED, st, 1'b1));
        end else begin
          seq    = st.nxt;
          st.nxt = seq + 32'd1;
          if (!st.trun) begin
            st.trun   = 1'b1;
            st.tcount = '0;
          end
          if (it.lom) begin
            st.msg_end  = seq;
            st.msg_pend = 1'b1;
          end
          rq.push_back(mk(EMIT_DATA, seq, 1'b0, ST_OK, st, 1'b1));
        end
      end
      ACT_RX: begin
        if (it.ptype != ACK_TYPE) begin
          rq.push_back(mk(EMIT_NONE, '0, 1'b0, ST_ACK_NO, st, 1'b1));
        end else if (st.phase == PH_OPEN) begin
          if (it.ack < st.base || it.ack >= st.nxt) begin
            rq.push_back(mk(EMIT_NONE, '0, 1'b0, ST_ACK_NO, st, 1'b1));
          end else begin
            // slide the window; stop the timer once nothing is left in flight
            st.base   = it.ack + 32'd1;
            st.trun   = (st.base != st.nxt);
            st.tcount = '0;
            stv = ST_ACK_OK;
            if (st.msg_pend && it.ack >= st.msg_end) begin
              st.msg_pend = 1'b0;
              stv = ST_MSG_DONE;
            end
            rq.push_back(mk(EMIT_NONE, '0, 1'b0, stv, st, 1'b1));
          end
        end else if (st.phase == PH_CLOSING && it.ack == st.nxt) begin
          st.phase  = PH_CLOSED;
          st.trun   = 1'b0;
          st.tcount = '0;
          rq.push_back(mk(EMIT_NONE, '0, 1'b0, ST_CLOSED, st, 1'b1));
        end else begin
          rq.push_back(mk(EMIT_NONE, '0, 1'b0, ST_ACK_NO, st, 1'b1));
        end
      end
      ACT_TICK: begin
        if (!st.trun) begin
          rq.push_back(mk(EMIT_NONE, '0, 1'b0, ST_OK, st, 1'b1));
        end else begin
          if (st.tcount != '1) st.tcount = st.tcount + 1'b1;
          if ({1'b0, st.tcount} < limit) begin
            rq.push_back(mk(EMIT_NONE, '0, 1'b0, ST_OK, st, 1'b1));
          end else begin
            st.tcount = '0;
            if (st.phase == PH_CLOSING) begin
              if (st.tries >= END_TRIES_MAX) begin
                st.phase = PH_GAVE_UP;
                st.trun  = 1'b0;
                rq.push_back(mk(EMIT_NONE, '0, 1'b0, ST_GAVE_UP, st, 1'b1));
              end else begin
                st.tries = st.tries + 2'd1;
                rq.push_back(mk(EMIT_END, st.nxt, 1'b1, ST_TIMEOUT, st, 1'b1));
              end
            end else if (st.phase == PH_OPEN && in_flight(st) != '0) begin
              // go back n: resend everything from the window base
              n = in_flight(st);
              if (n > 32'd64) n = 32'd64;
              for (k = 0; k < n; k++) begin
                rq.push_back(mk(EMIT_DATA, st.base + k, 1'b1, ST_TIMEOUT, st,
                                (k + 1) == n));
              end
            end else begin
              st.trun = 1'b0;
              rq.push_back(mk(EMIT_NONE, '0, 1'b0, ST_TIMEOUT, st, 1'b1));
            end
          end
        end
      end
      default: begin
        if (st.phase != PH_OPEN || in_flight(st) != '0) begin
          rq.push_back(mk(EMIT_NONE, '0, 1'b0, ST_REFUSED, st, 1'b1));
        end else begin
          st.phase  = PH_CLOSING;
          st.tries  = 2'd1;
          st.trun   = 1'b1;
          st.tcount = '0;
          rq.push_back(mk(EMIT_END, st.nxt, 1'b0, ST_OK, st, 1'b1));
        end
      end
    endcase
    return rq;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  // queue one item and track it in the planning state
  task automatic queue_item(input action_e a, input logic [7:0] p,
                            input logic [SEQ_W-1:0] ack, input logic lom);
    tx_item_t it;
    it.act   = a;
    it.ptype = p;
    it.ack   = ack;
    it.lom   = lom;
    void'(window_step(plan_st, it));
    item_q.push_back(it);
  endtask

  // mostly well-formed traffic: sends, in-window acks and ticks, some noise
  function automatic tx_item_t random_item(int unsigned send_pct);
    tx_item_t         it;
    logic [SEQ_W-1:0] o;
    int unsigned      r;
    o        = in_flight(plan_st);
    it.act   = ACT_SEND;
    it.ptype = 8'($urandom);
    it.ack   = $urandom;
    it.lom   = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 99) >= send_pct) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        it.act   = ACT_RX;
        it.ptype = ACK_TYPE;
        if (o == '0) it.ack = plan_st.nxt + $urandom_range(0, 2);
        else if ($urandom_range(0, 1) == 1)
          it.ack = plan_st.base + $urandom_range(0, (o > 32'd3) ? 32'd3 : o - 32'd1);
        else it.ack = plan_st.base + $urandom_range(0, o - 32'd1);
      end else if (r < 75) begin
        it.act = ACT_TICK;
      end else if (r < 92) begin
        it.act = ACT_RX;
        case ($urandom_range(0, 3))
          0: ;  // random type byte and number
          1: begin
            it.ptype = ACK_TYPE;
            it.ack   = plan_st.nxt + $urandom_range(0, 3);
          end
          2: begin
            it.ptype = ACK_TYPE;
            it.ack   = plan_st.base - 32'($urandom_range(1, 3));
          end
          default: it.ptype = ACK_TYPE;
        endcase
      end else if (o != '0) begin
        // close is only offered while it must be refused; a real close ends the run
        it.act = ACT_CLOSE;
      end
    end
    return it;
  endfunction

  // wait until every item went in and every result came out
  task automatic drain();
    do @(negedge clk_i);
    while (item_q.size() != 0 || in_valid || awaited_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_SIZE) cfg_win = val[6:0];
    else cfg_tout = val;
  endtask

  task automatic set_config(input logic [6:0] win, input logic [CFG_W-1:0] tout);
    drain();
    write_reg(REG_WINDOW_SIZE, CFG_W'(win));
    write_reg(REG_TIMEOUT, tout);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                             input logic [SEQ_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // ------------------------------------------------------------------------
  // Input driver: present queued items, idle at random, hold until accepted
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin : feed
    tx_item_t  it;
    result_q_t rq;
    logic      waiting;
    waiting = in_valid && !in_ready_o;
    if (in_valid && in_ready_o) begin
      rq = window_step(model_st, shown);
      foreach (rq[i]) awaited_q.push_back(rq[i]);
    end
    if (!waiting) begin
      if (rst_n && item_q.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
        it = item_q.pop_front();
        shown       <= it;
        in_valid    <= 1'b1;
        in_action   <= it.act;
        in_pkt_type <= it.ptype;
        in_ack_seq  <= it.ack;
        in_lom      <= it.lom;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result monitor and output backpressure
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin : sink
    tx_result_t want;
    if (out_valid_o && out_ready) begin
      if (awaited_q.size() == 0) begin
        $error("unexpected result: kind %0d seq %0h status %0d",
               emit_kind_o, tx_seq_o, status_o);
        n_fail++;
      end else begin
        want = awaited_q.pop_front();
        check_field("emit_kind", want.kind, emit_kind_o);
        check_field("tx_seq", want.seq, tx_seq_o);
        check_field("is_resend", want.resend, is_resend_o);
        check_field("status", want.status, status_o);
        check_field("outstanding", want.outst, outstanding_o);
        check_field("last", want.is_last, last_o);
      end
    end
    // a requested hold drops ready for a long stretch so the block backs up
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 35);
    end
  end

  always @(posedge clk_i) begin : watchdog
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------
  initial begin : stimulus
    logic [6:0]        win_tab  [PHASES];
    logic [CFG_W-1:0]  tout_tab [PHASES];
    logic [SEQ_W-1:0]  end_seq;
    int unsigned       ph;
    model_st = fresh_state();
    plan_st  = fresh_state();
    win_tab  = '{7'd1, 7'd127, 7'd3, 7'd64, 7'd8, 7'd0, 7'd2, 7'd5};
    tout_tab = '{16'd1, 16'd4, 16'd0, 16'hFFFF, 16'd2, 16'd3, 16'd5, 16'd12};
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // directed: reset settings, idle timer, declined acks, message completion
    queue_item(ACT_TICK, 8'h00, 32'h0, 1'b0);          // timer stopped
    queue_item(ACT_RX, 8'h00, 32'h0, 1'b0);            // not an ack
    queue_item(ACT_RX, ACK_TYPE, 32'h0, 1'b0);         // below base
    queue_item(ACT_RX, ACK_TYPE, 32'hFFFF_FFFF, 1'b0); // far beyond next
    queue_item(ACT_SEND, 8'h00, 32'h0, 1'b0);
    queue_item(ACT_SEND, 8'hFF, 32'hFFFF_FFFF, 1'b1);  // last of message
    queue_item(ACT_RX, 8'hA0, 32'h1, 1'b0);            // neighbor type bytes
    queue_item(ACT_RX, 8'hA2, 32'h1, 1'b0);
    queue_item(ACT_RX, ACK_TYPE, 32'h3, 1'b0);         // equal to next
    queue_item(ACT_RX, ACK_TYPE, 32'h1, 1'b0);         // partial slide
    queue_item(ACT_CLOSE, 8'h00, 32'h0, 1'b0);         // still outstanding
    queue_item(ACT_RX, ACK_TYPE, 32'h2, 1'b0);         // message done
    queue_item(ACT_RX, ACK_TYPE, 32'h2, 1'b1);         // now below base

    // directed: zero window and zero timeout act as one
    set_config(7'd0, 16'd0);
    queue_item(ACT_SEND, 8'h00, 32'h0, 1'b1);
    queue_item(ACT_SEND, 8'h00, 32'h0, 1'b0);          // window full
    queue_item(ACT_TICK, 8'h00, 32'h0, 1'b0);          // resend run of one
    queue_item(ACT_RX, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    queue_item(ACT_RX, ACK_TYPE, 32'h3, 1'b0);
    queue_item(ACT_TICK, 8'h00, 32'h0, 1'b0);

    // random phases; phase one stalls the output, phase two never idles
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) tout_tab[ph] = CFG_W'($urandom_range(2, 20));
      set_config(win_tab[ph], tout_tab[ph]);
      calm = (ph == 2);
      if (ph == 1) hold_ask++;
      repeat (PHASE_ITEMS) begin
        if (ph == 1) item_q.push_back(random_item(60));
        else item_q.push_back(random_item(40));
        void'(window_step(plan_st, item_q[item_q.size() - 1]));
      end
    end

    // close handshake: clear the window, close, then retry the end packet
    set_config(7'd8, 16'd2);
    calm = 1'b0;
    if (in_flight(plan_st) != '0) queue_item(ACT_RX, ACK_TYPE, plan_st.nxt - 32'd1, 1'b0);
    end_seq = plan_st.nxt;
    queue_item(ACT_CLOSE, 8'h00, 32'h0, 1'b0);
    queue_item(ACT_SEND, 8'h00, 32'h0, 1'b0);          // refused while closing
    queue_item(ACT_CLOSE, 8'h00, 32'h0, 1'b0);         // refused, not open
    queue_item(ACT_RX, ACK_TYPE, end_seq - 32'd1, 1'b0);
    queue_item(ACT_RX, ACK_TYPE, end_seq + 32'd1, 1'b0);
    queue_item(ACT_RX, 8'h5A, end_seq, 1'b0);
    repeat (2) queue_item(ACT_TICK, 8'h00, 32'h0, 1'b0); // second end packet
    if ($urandom_range(0, 1) == 1) begin
      queue_item(ACT_RX, ACK_TYPE, end_seq, 1'b0);     // end packet acked
    end else begin
      repeat (4) queue_item(ACT_TICK, 8'h00, 32'h0, 1'b0); // third try, give up
    end
    queue_item(ACT_RX, ACK_TYPE, end_seq, 1'b0);       // declined after close
    queue_item(ACT_SEND, 8'h00, 32'h0, 1'b1);
    queue_item(ACT_CLOSE, 8'h00, 32'h0, 1'b0);
    queue_item(ACT_TICK, 8'h00, 32'h0, 1'b0);

    drain();
    repeat (20) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : gbn_sender_window_control_tb
`default_nettype wire

@@ sim.f @@
hdl/gbnsw_pkg.sv
hdl/gbnsw_ctrl.sv
hdl/gbnsw_dp.sv
hdl/gbn_sender_window_control.sv
verif/gbn_sender_window_control_tb.sv
